// ===== sv/fpa_pkg.sv =====
package fpa_pkg;

  // Working value width and fraction bits (Q24.8 by default)
  localparam int VW        = 32;
  localparam int FRAC_BITS = 8;

  // Magnitude, product, division widths
  localparam int MW   = VW;                 // |x| up to 2^(VW-1)
  localparam int PW   = 2 * MW;             // |a|*|b|
  localparam int RW   = PW + 1;             // rounding sum, also widest magnitude
  localparam int NUMW = MW + FRAC_BITS;     // |a| << FRAC_BITS
  localparam int NDW  = NUMW + 2;           // 2*num + den
  localparam int DW   = MW + 1;             // 2*den

  localparam logic [RW-1:0] HALF =
    (FRAC_BITS > 0) ? (RW'(1) << ((FRAC_BITS > 0 ? FRAC_BITS : 1) - 1)) : '0;
  localparam logic [RW-1:0] LIM = RW'(1) << (VW - 1);

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MIN, OP_MAX, OP_GT, OP_LT,
    OP_GE, OP_LE, OP_EQ, OP_NE, OP_INC, OP_DEC, OP_INT2FIX, OP_FIX2INT
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_DIV0 = 2'd1,
    ERR_SAT  = 2'd2,
    ERR_RSVD = 2'd3
  } err_t;

  // One item on its way down the pipeline
  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic                  neg;     // sign of mul/div result
    logic [MW-1:0]         mag_a;
    logic [MW-1:0]         mag_b;
    logic signed [VW-1:0]  res;     // result of the single-stage operations
    logic                  cmp;
    err_t                  err;
    logic [PW-1:0]         prod;
    logic [NDW-1:0]        dvd;     // dividend, shifted out MSB first
    logic [DW-1:0]         den;
    logic [DW-1:0]         rem;
    logic [NDW-1:0]        quot;
  } pipe_t;

  typedef struct packed {
    logic signed [VW-1:0] v;
    logic                 sat;
  } sres_t;

  function automatic sres_t from_mag(input logic neg, input logic [RW-1:0] mag);
    sres_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > LIM) begin
        r.sat = 1'b1;
        r.v   = VMIN;
      end else begin
        r.v = VW'(~mag + RW'(1));
      end
    end else begin
      if (mag > LIM - RW'(1)) begin
        r.sat = 1'b1;
        r.v   = VMAX;
      end else begin
        r.v = VW'(mag);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/fpa_front.sv =====
module fpa_front import fpa_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [3:0]    in_cmd,
  input  logic [VW-1:0] in_a,
  input  logic [VW-1:0] in_b,
  output pipe_t         stg_r
);

  pipe_t                stg_nxt;
  logic signed [VW-1:0] a;
  logic signed [VW-1:0] b;
  logic signed [VW:0]   sum;
  logic signed [VW:0]   dif;
  logic [MW-1:0]        ma;
  logic [MW-1:0]        mb;

  always_comb begin
    a   = signed'(in_a);
    b   = signed'(in_b);
    sum = {a[VW-1], a} + {b[VW-1], b};
    dif = {a[VW-1], a} - {b[VW-1], b};
    ma  = a[VW-1] ? (~in_a + MW'(1)) : in_a;
    mb  = b[VW-1] ? (~in_b + MW'(1)) : in_b;

    stg_nxt       = '0;
    stg_nxt.valid = in_valid;
    stg_nxt.op    = op_t'(in_cmd);
    stg_nxt.neg   = a[VW-1] ^ b[VW-1];
    stg_nxt.mag_a = ma;
    stg_nxt.mag_b = mb;
    stg_nxt.err   = ERR_OK;
    stg_nxt.dvd   = (NDW'(ma) << (FRAC_BITS + 1)) + NDW'(mb);
    stg_nxt.den   = {mb, 1'b0};

    unique case (op_t'(in_cmd))
      OP_ADD: begin
        if (sum[VW] != sum[VW-1]) begin
          stg_nxt.res = sum[VW] ? VMIN : VMAX;
          stg_nxt.err = ERR_SAT;
        end else begin
          stg_nxt.res = sum[VW-1:0];
        end
      end
      OP_SUB: begin
        if (dif[VW] != dif[VW-1]) begin
          stg_nxt.res = dif[VW] ? VMIN : VMAX;
          stg_nxt.err = ERR_SAT;
        end else begin
          stg_nxt.res = dif[VW-1:0];
        end
      end
      OP_MIN:     stg_nxt.res = (a < b) ? a : b;
      OP_MAX:     stg_nxt.res = (a > b) ? a : b;
      OP_GT:      stg_nxt.cmp = a > b;
      OP_LT:      stg_nxt.cmp = a < b;
      OP_GE:      stg_nxt.cmp = a >= b;
      OP_LE:      stg_nxt.cmp = a <= b;
      OP_EQ:      stg_nxt.cmp = a == b;
      OP_NE:      stg_nxt.cmp = a != b;
      OP_INC:     stg_nxt.res = a + VW'(1);
      OP_DEC:     stg_nxt.res = a - VW'(1);
      OP_INT2FIX: stg_nxt.res = a <<< FRAC_BITS;
      OP_FIX2INT: stg_nxt.res = a >>> FRAC_BITS;
      default: begin
        // mul and div finish at the back end; flag a zero divisor now
        if (op_t'(in_cmd) == OP_DIV && mb == '0) stg_nxt.err = ERR_DIV0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (en) begin
      stg_r <= stg_nxt;
    end
  end

endmodule

// ===== sv/fpa_mul.sv =====
module fpa_mul import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  pipe_t stg_i,
  output pipe_t stg_r
);

  pipe_t stg_nxt;

  // Form the magnitude product; rounding waits for the back end
  always_comb begin
    stg_nxt      = stg_i;
    stg_nxt.prod = stg_i.mag_a * stg_i.mag_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (en) begin
      stg_r <= stg_nxt;
    end
  end

endmodule

// ===== sv/fpa_div_step.sv =====
module fpa_div_step import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  pipe_t stg_i,
  output pipe_t stg_r
);

  pipe_t       stg_nxt;
  logic [DW:0] trial;
  logic [DW:0] diff;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    stg_nxt = stg_i;
    trial   = {stg_i.rem, stg_i.dvd[NDW-1]};
    diff    = trial - {1'b0, stg_i.den};
    stg_nxt.dvd = stg_i.dvd << 1;
    if (!diff[DW]) begin
      stg_nxt.rem  = diff[DW-1:0];
      stg_nxt.quot = {stg_i.quot[NDW-2:0], 1'b1};
    end else begin
      stg_nxt.rem  = trial[DW-1:0];
      stg_nxt.quot = {stg_i.quot[NDW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (en) begin
      stg_r <= stg_nxt;
    end
  end

endmodule

// ===== sv/fpa_back.sv =====
module fpa_back import fpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  pipe_t                stg_i,
  output logic                 valid_r,
  output logic signed [VW-1:0] res_r,
  output logic                 cmp_r,
  output err_t                 err_r
);

  logic [RW-1:0]        mq;
  sres_t                ms;
  sres_t                ds;
  logic signed [VW-1:0] res_nxt;
  err_t                 err_nxt;

  always_comb begin
    mq      = (RW'(stg_i.prod) + HALF) >> FRAC_BITS;
    ms      = from_mag(stg_i.neg, mq);
    ds      = from_mag(stg_i.neg, RW'(stg_i.quot));
    res_nxt = stg_i.res;
    err_nxt = stg_i.err;
    unique case (stg_i.op)
      OP_MUL: begin
        res_nxt = ms.v;
        err_nxt = ms.sat ? ERR_SAT : ERR_OK;
      end
      OP_DIV: begin
        if (stg_i.err == ERR_DIV0) begin
          res_nxt = '0;
        end else begin
          res_nxt = ds.v;
          err_nxt = ds.sat ? ERR_SAT : ERR_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stg_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      cmp_r <= stg_i.cmp;
      err_r <= err_nxt;
    end
  end

endmodule

// ===== sv/fixed_point_alu.sv =====
// Signed fixed-point ALU, raw operands with FRAC_BITS fraction bits (Q24.8).
// Input channel in_*: one item per handshake carrying cmd, operand_a and
// operand_b. Output channel out_*: one item per input item, in order,
// carrying result_value, compare_true and error_code.
// Path: NDW + 3 register stages (NDW is 42 at Q24.8) from the input
// handshake to output valid: one decode stage, one multiplier stage, one
// stage per quotient bit of the restoring divider, one output stage. Every
// operation takes the same path, so ordering is kept without tags.
// Throughput: one item per cycle while the receiver does not stall; the
// divider is fully unrolled, one quotient bit per stage, and sets the depth.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not
// cleared. When the receiver stalls with a result waiting, the whole
// pipeline freezes and in_tready drops; no item is lost or repeated. While
// the output stage is empty, the pipeline keeps advancing and bubbles drain.
// Multiply and divide round half away from zero and saturate, as do add and
// subtract; division by zero gives 0 with error_code 1.
module fixed_point_alu import fpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [3:0] cmd, [35:4] operand_a, [67:36] operand_b, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] result_value, [32] compare_true,
                                  // [34:33] error_code, zero pad
);

  logic                 en;
  pipe_t                front_r;
  pipe_t                mul_r;
  pipe_t                div_r [NDW+1];
  logic signed [VW-1:0] res_r;
  logic                 cmp_r;
  err_t                 err_r;

  // Advance everything when the output register is free or being taken
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  fpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_cmd   (in_tdata[3:0]),
    .in_a     (in_tdata[35:4]),
    .in_b     (in_tdata[67:36]),
    .stg_r    (front_r)
  );

  fpa_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .stg_i (front_r),
    .stg_r (mul_r)
  );

  // Start the divider with an empty remainder and quotient
  always_comb begin
    div_r[0]      = mul_r;
    div_r[0].rem  = '0;
    div_r[0].quot = '0;
  end

  for (genvar i = 0; i < NDW; i++) begin : g_div
    fpa_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .stg_i (div_r[i]),
      .stg_r (div_r[i+1])
    );
  end

  fpa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .stg_i   (div_r[NDW]),
    .valid_r (out_tvalid),
    .res_r   (res_r),
    .cmp_r   (cmp_r),
    .err_r   (err_r)
  );

  assign out_tdata = {5'b0, err_r, cmp_r, res_r};

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> err_r != ERR_RSVD)
    else $error("reserved error code on output");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cmp_r |-> res_r == '0 && err_r == ERR_OK)
    else $error("comparison item with nonzero result");

  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err_r == ERR_DIV0 |-> res_r == '0)
    else $error("division by zero with nonzero result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule
